@@ sv/ilist_pkg.sv @@
package ilist_pkg;

    // Operation codes carried in the request's tuser field.
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_FIND   = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_RANGE    = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    // Commands broadcast to the row of cells.
    localparam logic [1:0] CMD_NOP    = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_ROTATE = 2'd3;

    localparam int DATA_W = 32;

    typedef struct packed {
        logic [1:0]        op;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

    typedef struct packed {
        logic [4:0]        item_count;
        logic [DATA_W-1:0] read_value;
        logic [3:0]        found_position;
        logic [1:0]        status;
    } result_t;

endpackage

@@ sv/indexed_list_insert_delete_search.sv @@
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// position 0 in cell 0. Each request carries an operation in tuser (insert,
// delete, find first match, read position) and returns exactly one result
// with a status (ok, full, out of range, not found) and the entry count after
// the operation. Insert and delete move the whole row at once, and such a
// request and any request rejected for range or fullness puts its result
// straight into the holding register. Find and an in-range read rotate the
// row once around through cell 0, where a single comparator and capture
// register look at one entry a cycle. One finished result can wait in a
// holding register while the output register is stalled, so the next
// request is accepted even while the output waits.
module indexed_list_insert_delete_search import ilist_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position [4:0], value [36:5], zeros above
    input  logic [1:0]  s_tuser,   // mode [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status [1:0], found_position [5:2],
                                   // read_value [37:6], item_count [42:38],
                                   // zeros above
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = CNT_W + 5;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Request fields.
    logic [1:0]        in_mode;
    logic [4:0]        in_position;
    logic [DATA_W-1:0] in_value;

    assign in_mode     = s_tuser;
    assign in_position = s_tdata[4:0];
    assign in_value    = s_tdata[36:5];

    // Control state.
    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic              is_find_reg, is_find_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  found_reg, found_next;
    logic [DATA_W-1:0] rd_reg, rd_next;

    // Holding register and output register.
    logic              pend_valid_reg, pend_valid_next;
    result_t           pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    cell_cmd_t         cmd;
    logic [IDX_W-1:0]  cell_pos;
    logic [DATA_W-1:0] cell_data [CAPACITY];

    logic              accept;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic              is_full;
    logic [CNT_W-1:0]  step_cnt;
    logic [IDX_W+3:0]  found_wide;
    logic [CNT_W+4:0]  count_wide;
    logic [CNT_W+4:0]  count_next_wide;

    assign s_tready = (state_reg == ST_IDLE) && !pend_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign pos_ext  = CMP_W'(in_position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign step_cnt = CNT_W'(step_reg);

    assign found_wide      = {4'd0, found_reg};
    assign count_wide      = {5'd0, count_reg};
    assign count_next_wide = {5'd0, count_next};

    // The row of cells; each neighbor wraps around at the ends so that a full
    // rotation brings every entry back to its place.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            ilist_cell #(
                .IDX_W (IDX_W),
                .INDEX (gi)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .pos        (cell_pos),
                .left_data  (cell_data[(gi + CAPACITY - 1) % CAPACITY]),
                .right_data (cell_data[(gi + 1) % CAPACITY]),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        is_find_next    = is_find_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        hit_next        = hit_reg;
        found_next      = found_reg;
        rd_next         = rd_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        cmd.op          = CMD_NOP;
        cmd.value       = in_value;
        cell_pos        = pos_ext[IDX_W-1:0];

        // Output side: the held result moves on whenever the output register
        // is free or being emptied in this cycle.
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        if (pend_valid_reg && (!out_valid_reg || m_tready))
        begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            pend_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_next.status         = STAT_OK;
                    pend_next.found_position = 4'd0;
                    pend_next.read_value     = '0;
                    step_next    = '0;
                    hit_next     = 1'b0;
                    found_next   = '0;
                    rd_next      = '0;
                    key_next     = in_value;
                    pos_next     = pos_ext[IDX_W-1:0];
                    is_find_next = (in_mode == MODE_FIND);
                    case (in_mode)
                        MODE_INSERT:
                        begin
                            pend_valid_next = 1'b1;
                            if (is_full)
                                pend_next.status = STAT_FULL;
                            else if (pos_ext > cnt_ext)
                                pend_next.status = STAT_RANGE;
                            else
                            begin
                                cmd.op     = CMD_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_DELETE:
                        begin
                            pend_valid_next = 1'b1;
                            if (pos_ext >= cnt_ext)
                                pend_next.status = STAT_RANGE;
                            else
                            begin
                                cmd.op     = CMD_DELETE;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        MODE_FIND:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                pend_valid_next  = 1'b1;
                                pend_next.status = STAT_RANGE;
                            end
                            else
                                state_next = ST_SCAN;
                        end
                    endcase
                    pend_next.item_count = count_next_wide[4:0];
                end
            end
            ST_SCAN:
            begin
                // Cell 0 holds the entry at list position step_reg.
                cmd.op = CMD_ROTATE;
                if (is_find_reg && !hit_reg && (step_cnt < count_reg)
                    && (cell_data[0] == key_reg))
                begin
                    hit_next   = 1'b1;
                    found_next = step_reg;
                end
                if (!is_find_reg && (step_reg == pos_reg))
                    rd_next = cell_data[0];
                step_next = step_reg + IDX_W'(1);
                if (step_reg == IDX_W'(CAPACITY - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                pend_valid_next          = 1'b1;
                pend_next.item_count     = count_wide[4:0];
                pend_next.read_value     = rd_reg;
                pend_next.found_position = found_wide[3:0];
                pend_next.status         = STAT_OK;
                if (is_find_reg && !hit_reg)
                begin
                    pend_next.status         = STAT_NOTFOUND;
                    pend_next.found_position = 4'd0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            step_reg       <= '0;
            hit_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            hit_reg        <= hit_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_find_reg <= is_find_next;
        pos_reg     <= pos_next;
        key_reg     <= key_next;
        found_reg   <= found_next;
        rd_reg      <= rd_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg};

    // The entry count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // While the row rotates, no result may be waiting in the holding register.
    a_scan_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !pend_valid_reg)
        else $error("held result present during a scan");

    // A successful insert grows the list by exactly one entry.
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_mode == MODE_INSERT) && !is_full && (pos_ext <= cnt_ext))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list by one");

    // The count only changes on an accepted request.
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("entry count changed without a request");

endmodule

@@ sv/ilist_cell.sv @@
module ilist_cell import ilist_pkg::*; #(
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  logic              clk,
    input  cell_cmd_t         cmd,
    input  logic [IDX_W-1:0]  pos,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [IDX_W-1:0]  my_idx;

    assign my_idx = IDX_W'(INDEX);

    // Insert shifts entries above the position up and loads the new value at
    // the position; delete shifts entries from the position on down; rotate
    // moves every entry one place toward the head.
    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            CMD_INSERT:
            begin
                if (my_idx > pos)
                    data_next = left_data;
                else if (my_idx == pos)
                    data_next = cmd.value;
            end
            CMD_DELETE:
            begin
                if (my_idx >= pos)
                    data_next = right_data;
            end
            CMD_ROTATE:
            begin
                data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
